// ----- rtl/blbd_pkg.sv -----
package blbd_pkg;

  localparam int unsigned HistDepth = 4096;
  localparam int unsigned HistAw = $clog2(HistDepth);
  localparam int unsigned BytesPerResult = 8;

  typedef enum logic [6:0] {
    TS_KIND     = 7'b0000001,
    TS_SHORT    = 7'b0000010,
    TS_SELECT   = 7'b0000100,
    TS_MATCHLEN = 7'b0001000,
    TS_OFFSET   = 7'b0010000,
    TS_LITCOUNT = 7'b0100000,
    TS_LITBYTE  = 7'b1000000
  } token_step_e;

  typedef enum logic [3:0] {
    PH_LENGTH = 4'b0001,
    PH_SEED   = 4'b0010,
    PH_DECODE = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BIT   = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_WR    = 7'b0001000,
    ST_SEND  = 7'b0010000,
    ST_CLEAR = 7'b0100000,
    ST_SEEK  = 7'b1000000
  } ctrl_e;

endpackage

// ----- rtl/blbd_ram.sv -----
module blbd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- rtl/backward_lz_bit_decruncher_top.sv -----
// Channel | Direction | tdata (low bit up)                | tuser / tlast
// s_axis  | in        | packed_word[31:0]                 | tuser: final_word
// m_axis  | out       | out_bytes[63:0], byte_count[67:64] | tuser: finished_ok, failed
//         |           | zero fill to 72 bits              | tlast: last_of_item
//
// After reset the history memory is cleared, one byte a cycle, over all 4096 entries,
// and no word is accepted during that sweep.
// A word is accepted, then its buffer bits (at most 32) are consumed one at a time;
// each match byte is a history read, then a write, and one more read step ends the
// match; each full result is passed on, and the word closes with an end check, then a send.
// The seed word first scans down from bit 31 for its marker bit.
// One word is processed at a time; the output register holds a result until m_axis_tready
// is high, and the decoder waits only when another result is due while it is full.
module backward_lz_bit_decruncher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // packed_word
  input  logic        s_axis_tuser,  // final_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // out_bytes, byte_count, zero fill
  output logic [1:0]  m_axis_tuser,  // finished_ok, failed
  output logic        m_axis_tlast   // last_of_item
);
  import blbd_pkg::*;

  ctrl_e       st_q, st_d;
  phase_e      ph_q, ph_d;
  token_step_e ts_q, ts_d;
  logic [31:0] buf_q, buf_d;
  logic [5:0]  left_q, left_d;
  logic [31:0] rem_q, rem_d, wr_q, wr_d;
  logic [11:0] fv_q, fv_d;
  logic [3:0]  fbl_q, fbl_d;
  logic [8:0]  run_q, run_d;
  logic [11:0] dist_q, dist_d;
  logic [HistAw-1:0] hp_q, hp_d, clr_q, clr_d;
  logic [63:0] pk_q, pk_d;
  logic [3:0]  pc_q, pc_d;
  logic        fin_q, fin_d;
  logic        ov_q, ov_d;
  logic [63:0] ob_q, ob_d;
  logic [3:0]  obc_q, obc_d;
  logic        ou_ok_q, ou_ok_d, ou_bad_q, ou_bad_d, ol_q, ol_d;

  logic              we;
  logic [HistAw-1:0] waddr, raddr;
  logic [7:0]        wdata, rdata;

  blbd_ram #(.Width(8), .Depth(HistDepth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {4'b0, obc_q, ob_q};
  assign m_axis_tuser  = {ou_bad_q, ou_ok_q};
  assign m_axis_tlast  = ol_q;
  assign raddr = hp_q - dist_q[HistAw-1:0];

  logic b;
  logic [11:0] fvn;
  assign b   = buf_q[0];
  assign fvn = {fv_q[10:0], b};

  always_comb begin
    st_d = st_q; ph_d = ph_q; ts_d = ts_q; buf_d = buf_q; left_d = left_q;
    rem_d = rem_q; wr_d = wr_q; fv_d = fv_q; fbl_d = fbl_q; run_d = run_q;
    dist_d = dist_q; hp_d = hp_q; clr_d = clr_q; pk_d = pk_q; pc_d = pc_q;
    fin_d = fin_q; ov_d = ov_q; ob_d = ob_q; obc_d = obc_q; ou_ok_d = ou_ok_q;
    ou_bad_d = ou_bad_q; ol_d = ol_q;
    we = 1'b0; waddr = hp_q; wdata = rdata;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (st_q)
      ST_CLEAR: begin
        we = 1'b1; waddr = clr_q; wdata = 8'd0;
        clr_d = clr_q + 1'b1;
        if (clr_q == HistAw'(HistDepth - 1)) st_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          pk_d = '0; pc_d = '0; fin_d = s_axis_tuser;
          case (ph_q)
            PH_LENGTH: begin
              rem_d = s_axis_tdata; wr_d = '0;
              ph_d = (s_axis_tdata == 32'd0 || s_axis_tuser) ? PH_HALT : PH_SEED;
              st_d = ST_SEND;
            end
            PH_SEED: begin
              buf_d = s_axis_tdata; left_d = 6'd31; ts_d = TS_KIND;
              st_d = ST_SEEK;
            end
            PH_DECODE: begin
              buf_d = s_axis_tdata; left_d = 6'd32; st_d = ST_BIT;
            end
            default: st_d = ST_SEND;
          endcase
        end
      end
      ST_SEEK: begin
        // Scan down from bit 31 for the marker; the bits below it are the payload.
        // Bit 0 is never a marker, so the scan stops there with nothing to decode.
        if (left_q == 6'd0 || buf_q[left_q[4:0]]) begin
          ph_d = PH_DECODE; st_d = ST_BIT;
        end else begin
          left_d = left_q - 1'b1;
        end
      end
      ST_BIT: begin
        if (ph_q != PH_DECODE) begin
          st_d = ST_SEND;
        end else if (ts_q == TS_KIND && rem_q == 32'd0) begin
          ph_d = PH_HALT; st_d = ST_SEND;
        end else if (left_q == 6'd0) begin
          if (fin_q) ph_d = PH_HALT;
          st_d = ST_SEND;
        end else if (pc_q == 4'(BytesPerResult) && ts_q == TS_LITBYTE && fbl_q == 4'd1) begin
          // A full result is only passed on once another byte is due, so that the
          // end of the word can still mark it as the last one.
          if (!ov_q || m_axis_tready) begin
            ov_d = 1'b1; ob_d = pk_q; obc_d = pc_q; ou_ok_d = 0; ou_bad_d = 0;
            ol_d = 0; pk_d = '0; pc_d = '0;
          end
        end else begin
          buf_d = {1'b0, buf_q[31:1]}; left_d = left_q - 1'b1;
          case (ts_q)
            TS_KIND: begin
              if (b) begin fv_d = '0; fbl_d = 4'd2; ts_d = TS_SELECT; end
              else ts_d = TS_SHORT;
            end
            TS_SHORT: begin
              if (b) begin
                if (rem_q < 32'd2) ph_d = PH_HALT;
                else begin run_d = 9'd2; fv_d = '0; fbl_d = 4'd8; ts_d = TS_OFFSET; end
              end else begin
                run_d = 9'd1; fv_d = '0; fbl_d = 4'd3; ts_d = TS_LITCOUNT;
              end
            end
            default: begin
              fv_d = fvn; fbl_d = fbl_q - 1'b1;
              if (fbl_q == 4'd1) begin
                fv_d = '0;
                case (ts_q)
                  TS_SELECT: begin
                    case (fvn[1:0])
                      2'd0: if (rem_q < 32'd3) ph_d = PH_HALT;
                            else begin run_d = 9'd3; fbl_d = 4'd9; ts_d = TS_OFFSET; end
                      2'd1: if (rem_q < 32'd4) ph_d = PH_HALT;
                            else begin run_d = 9'd4; fbl_d = 4'd10; ts_d = TS_OFFSET; end
                      2'd2: begin fbl_d = 4'd8; ts_d = TS_MATCHLEN; end
                      default: begin run_d = 9'd9; fbl_d = 4'd8; ts_d = TS_LITCOUNT; end
                    endcase
                  end
                  TS_MATCHLEN: begin
                    if ({24'd0, fvn[7:0]} + 32'd1 > rem_q) ph_d = PH_HALT;
                    else begin run_d = {1'b0, fvn[7:0]} + 9'd1; fbl_d = 4'd12;
                      ts_d = TS_OFFSET; end
                  end
                  TS_OFFSET: begin
                    dist_d = fvn;
                    if ({20'd0, fvn} > wr_q) ph_d = PH_HALT;
                    else st_d = ST_RD;
                  end
                  TS_LITCOUNT: begin
                    run_d = run_q + {1'b0, fvn[7:0]};
                    if ({23'd0, run_q} + {24'd0, fvn[7:0]} > rem_q) ph_d = PH_HALT;
                    else begin fbl_d = 4'd8; ts_d = TS_LITBYTE; end
                  end
                  default: begin
                    we = 1'b1; wdata = fvn[7:0];
                    hp_d = hp_q + 1'b1; wr_d = wr_q + 1; rem_d = rem_q - 1;
                    pk_d = pk_q | ({56'd0, fvn[7:0]} << {pc_q[2:0], 3'b0});
                    pc_d = pc_q + 1'b1; run_d = run_q - 1'b1;
                    if (run_q == 9'd1) ts_d = TS_KIND;
                    else fbl_d = 4'd8;
                  end
                endcase
              end
            end
          endcase
        end
      end
      ST_RD: begin
        // memory read issued this cycle at raddr
        if (run_q == 9'd0) begin ts_d = TS_KIND; st_d = ST_BIT; end
        else if (pc_q == 4'(BytesPerResult)) begin
          if (!ov_q || m_axis_tready) begin
            ov_d = 1'b1; ob_d = pk_q; obc_d = pc_q; ou_ok_d = 0; ou_bad_d = 0;
            ol_d = 0; pk_d = '0; pc_d = '0;
          end
        end else st_d = ST_WR;
      end
      ST_WR: begin
        we = 1'b1; wdata = rdata;
        hp_d = hp_q + 1'b1; wr_d = wr_q + 1; rem_d = rem_q - 1;
        pk_d = pk_q | ({56'd0, rdata} << {pc_q[2:0], 3'b0});
        pc_d = pc_q + 1'b1; run_d = run_q - 1'b1;
        st_d = ST_RD;
      end
      ST_SEND: begin
        if (ph_q == PH_SEED || ph_q == PH_DECODE) begin
          if (fin_q) ph_d = PH_HALT;
        end
        if (!ov_q || m_axis_tready) begin
          ov_d = 1'b1; ob_d = pk_q; obc_d = pc_q; ol_d = 1'b1;
          if (ph_d == PH_HALT) begin
            ou_ok_d = (rem_q == 32'd0); ou_bad_d = (rem_q != 32'd0);
          end else begin
            ou_ok_d = 1'b0; ou_bad_d = 1'b0;
          end
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_CLEAR; ph_q <= PH_LENGTH; ts_q <= TS_KIND; left_q <= '0;
      rem_q <= '0; wr_q <= '0; fbl_q <= '0; run_q <= '0; hp_q <= '0;
      clr_q <= '0; pc_q <= '0; ov_q <= 1'b0; fin_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d; ts_q <= ts_d; left_q <= left_d;
      rem_q <= rem_d; wr_q <= wr_d; fbl_q <= fbl_d; run_q <= run_d; hp_q <= hp_d;
      clr_q <= clr_d; pc_q <= pc_d; ov_q <= ov_d; fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d; fv_q <= fv_d; dist_q <= dist_d; pk_q <= pk_d;
    ob_q <= ob_d; obc_q <= obc_d; ou_ok_q <= ou_ok_d; ou_bad_q <= ou_bad_d;
    ol_q <= ol_d;
  end
endmodule
